>>> src/ialuh_pkg.sv
`timescale 1ns / 1ps

package ialuh_pkg;

	// Default number of history entries.
	localparam int HISTORY_DEPTH_DEF = 1024;

	// Field widths fixed by the interface.
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 11;

	// Command codes. The unused code is decoded as a history read.
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 3'd0,
		CMD_SUB     = 3'd1,
		CMD_MUL     = 3'd2,
		CMD_DIV     = 3'd3,
		CMD_POW     = 3'd4,
		CMD_SQRT    = 3'd5,
		CMD_READ    = 3'd6,
		CMD_READ_UN = 3'd7
	} cmd_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 3'd0,
		STAT_DIV0    = 3'd1,
		STAT_NEGROOT = 3'd2,
		STAT_FULL    = 3'd3,
		STAT_BADIDX  = 3'd4
	} status_t;

endpackage

>>> src/integer_alu_with_history_top.sv
`timescale 1ns / 1ps

// Integer ALU with a result history memory.
// The input channel (in_valid, in_stall) carries one transaction of command,
// operand_a and operand_b. The output channel (out_valid, out_stall) returns
// one transaction of result_value, status and stored_count for each input.
// Every successful arithmetic result is appended to the history; a read
// command returns the entry at index operand_a.
// Add and subtract go from setup straight to finish. Multiply and power
// iterate once per exponent bit up to the highest set bit, through the two
// multipliers; divide runs 32 restoring steps, one quotient bit a cycle,
// and the square root 16 steps, one result bit a cycle. A read waits in
// the read-wait state. Errors detected at setup go straight to finish.
// One item is in flight at a time: in_stall is high from acceptance until the
// result moves into the output register, so a new transaction waits for the
// previous result to be loaded. The next item is taken while a finished
// result still waits in the output register; if the receiver stalls, the
// following result holds in the finish state until the output frees up.
// Reset clears the history count and the output valid flag and returns the
// sequencer to idle; the history memory itself is not cleared, and entries
// are read only below the count.

module integer_alu_with_history_top
	import ialuh_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [CMD_W-1:0]           command,
	input  logic signed [DATA_W-1:0]   operand_a,
	input  logic signed [DATA_W-1:0]   operand_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [DATA_W-1:0]   result_value,
	output logic [STATUS_W-1:0]        status,
	output logic [COUNT_W-1:0]         stored_count
);

	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_ITER,
		ST_RDWAIT,
		ST_FINISH
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [DATA_W-1:0]   a_q;
	logic [DATA_W-1:0]   b_q;
	logic [DATA_W-1:0]   x_q;
	logic [DATA_W-1:0]   y_q;
	logic [DATA_W-1:0]   z_q;
	logic [4:0]          step_q;
	logic                neg_q;
	logic [DATA_W-1:0]   val_q;
	status_t             stat_q;
	logic [CW-1:0]       count_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_value_q;
	status_t             out_stat_q;
	logic [COUNT_W-1:0]  out_count_q;

	// History memory with one write and one registered read port.
	logic [DATA_W-1:0]   hist_mem [HISTORY_DEPTH];
	logic [DATA_W-1:0]   rd_data_q;
	logic                mem_we;
	logic                mem_re;

	logic                accept;
	logic                is_read;
	logic                can_load;
	logic                index_bad;
	logic                hist_full;
	status_t             fin_stat;
	logic [DATA_W-1:0]   fin_value;
	logic [CW-1:0]       count_next;

	// Iteration datapath outputs.
	logic [DATA_W-1:0]   mul_acc;
	logic [DATA_W-1:0]   mul_sq;
	logic [DATA_W:0]     div_trial;
	logic [DATA_W:0]     div_diff;
	logic                div_ge;
	logic [DATA_W-1:0]   div_rem;
	logic [DATA_W-1:0]   div_quo;
	logic [DATA_W-1:0]   sq_trial;
	logic                sq_ge;
	logic [DATA_W-1:0]   sq_rem;
	logic [DATA_W-1:0]   sq_root;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign is_read  = (cmd_q == CMD_READ) || (cmd_q == CMD_READ_UN);
	assign can_load = !out_valid_q || !out_stall;

	// A read index is bad when negative or not below the stored count.
	assign index_bad = a_q[DATA_W-1] || (a_q >= DATA_W'(count_q));
	assign hist_full = (count_q == CW'(HISTORY_DEPTH));

	// Square-and-multiply: accumulator times base, and base squared.
	assign mul_acc = y_q[0] ? (z_q * x_q) : z_q;
	assign mul_sq  = x_q * x_q;

	// Restoring division step: one quotient bit shifts into x_q.
	assign div_trial = {z_q, x_q[DATA_W-1]};
	assign div_diff  = div_trial - {1'b0, y_q};
	assign div_ge    = !div_diff[DATA_W];
	assign div_rem   = div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
	assign div_quo   = {x_q[DATA_W-2:0], div_ge};

	// Integer square root step: y_q walks down the even bit positions.
	assign sq_trial = z_q + y_q;
	assign sq_ge    = (x_q >= sq_trial);
	assign sq_rem   = sq_ge ? (x_q - sq_trial) : x_q;
	assign sq_root  = sq_ge ? ((z_q >> 1) + y_q) : (z_q >> 1);

	// Final status, with a full history checked after operand errors.
	always_comb begin
		if (stat_q == STAT_OK && !is_read && hist_full) begin
			fin_stat = STAT_FULL;
		end else begin
			fin_stat = stat_q;
		end
		fin_value = (fin_stat == STAT_OK) ? val_q : '0;
	end

	assign mem_we     = (state_q == ST_FINISH) && can_load && (fin_stat == STAT_OK) && !is_read;
	assign mem_re     = (state_q == ST_SETUP) && is_read && !index_bad;
	assign count_next = mem_we ? (count_q + CW'(1)) : count_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[count_q[AW-1:0]] <= val_q;
		end
		if (mem_re) begin
			rd_data_q <= hist_mem[a_q[AW-1:0]];
		end
	end

	// Sequencer, datapath registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= cmd_t'(command);
						a_q     <= operand_a;
						b_q     <= operand_b;
						stat_q  <= STAT_OK;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					unique case (cmd_q)
						CMD_ADD: begin
							val_q   <= a_q + b_q;
							state_q <= ST_FINISH;
						end
						CMD_SUB: begin
							val_q   <= a_q - b_q;
							state_q <= ST_FINISH;
						end
						CMD_MUL: begin
							// A product is a power run with exponent one.
							z_q     <= a_q;
							x_q     <= b_q;
							y_q     <= DATA_W'(1);
							state_q <= ST_ITER;
						end
						CMD_DIV: begin
							if (b_q == '0) begin
								stat_q  <= STAT_DIV0;
								state_q <= ST_FINISH;
							end else begin
								x_q     <= a_q[DATA_W-1] ? ('0 - a_q) : a_q;
								y_q     <= b_q[DATA_W-1] ? ('0 - b_q) : b_q;
								z_q     <= '0;
								neg_q   <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
								step_q  <= 5'd31;
								state_q <= ST_ITER;
							end
						end
						CMD_POW: begin
							if (b_q[DATA_W-1] || b_q == '0) begin
								val_q   <= DATA_W'(1);
								state_q <= ST_FINISH;
							end else begin
								z_q     <= DATA_W'(1);
								x_q     <= a_q;
								y_q     <= b_q;
								state_q <= ST_ITER;
							end
						end
						CMD_SQRT: begin
							if (a_q[DATA_W-1]) begin
								stat_q  <= STAT_NEGROOT;
								state_q <= ST_FINISH;
							end else begin
								x_q     <= a_q;
								z_q     <= '0;
								y_q     <= DATA_W'(1) << (DATA_W - 2);
								state_q <= ST_ITER;
							end
						end
						CMD_READ, CMD_READ_UN: begin
							if (index_bad) begin
								stat_q  <= STAT_BADIDX;
								state_q <= ST_FINISH;
							end else begin
								state_q <= ST_RDWAIT;
							end
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_ITER: begin
					unique case (cmd_q)
						CMD_DIV: begin
							x_q    <= div_quo;
							z_q    <= div_rem;
							step_q <= step_q - 5'd1;
							if (step_q == '0) begin
								val_q   <= neg_q ? ('0 - div_quo) : div_quo;
								state_q <= ST_FINISH;
							end
						end
						CMD_SQRT: begin
							x_q <= sq_rem;
							z_q <= sq_root;
							y_q <= y_q >> 2;
							if (y_q[DATA_W-1:2] == '0) begin
								val_q   <= sq_root;
								state_q <= ST_FINISH;
							end
						end
						default: begin
							// Multiply and power share the square-and-multiply loop.
							z_q <= mul_acc;
							x_q <= mul_sq;
							y_q <= y_q >> 1;
							if (y_q[DATA_W-1:1] == '0) begin
								val_q   <= mul_acc;
								state_q <= ST_FINISH;
							end
						end
					endcase
				end
				ST_RDWAIT: begin
					val_q   <= rd_data_q;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (can_load) begin
						out_value_q <= fin_value;
						out_stat_q  <= fin_stat;
						out_count_q <= COUNT_W'(count_next);
						count_q     <= count_next;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_stat_q;
	assign stored_count = out_count_q;

endmodule

>>> src/ialuh_checker.sv
`timescale 1ns / 1ps

module ialuh_checker
	import ialuh_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [CMD_W-1:0]         command,
	input logic signed [DATA_W-1:0] operand_a,
	input logic signed [DATA_W-1:0] operand_b,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DATA_W-1:0] result_value,
	input logic [STATUS_W-1:0]      status,
	input logic [COUNT_W-1:0]       stored_count
);

	// The block works on one transaction at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a transaction was in flight");

	// An error result carries a zero value.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> (result_value == '0))
		else $error("error result with nonzero value");

	// The reported count never exceeds the history depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (HISTORY_DEPTH <= 2047) |-> (stored_count <= COUNT_W'(HISTORY_DEPTH)))
		else $error("stored count beyond history depth");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(status)
			&& $stable(stored_count))
		else $error("stalled output transaction changed");

endmodule

bind integer_alu_with_history_top ialuh_checker #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_ialuh_checker (.*);
